/* hdl/kvt_pkg.sv */
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants for the key/value table: table size, command and
// status codes, the search item that walks the cell chain and the write bus.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int OUT_CNT_W   = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_DONE
  } state_t;

  // Search item handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic             vld;
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic             free_seen;
    logic [IDX_W-1:0] free_idx;
    logic [VAL_W-1:0] fval;
  } tok_t;

  // Broadcast write of a new entry at the end of an insert
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } wr_t;

endpackage

/* hdl/kvt_cell.sv */
// ----------------------------------------------------------------------------
// kvt_cell
// One table entry. Compares the passing search item against its key, notes a
// hit or a free slot, clears itself on an erase hit and takes a broadcast write.
// ----------------------------------------------------------------------------
module kvt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [kvt_pkg::IDX_W-1:0] my_idx,
  input  kvt_pkg::tok_t             tok_in,
  input  kvt_pkg::wr_t              wr,
  output kvt_pkg::tok_t             tok_out
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic [kvt_pkg::KEY_W-1:0] key_r;
  logic [kvt_pkg::VAL_W-1:0] value_r;
  kvt_pkg::tok_t             tok_r;
  kvt_pkg::tok_t             tok_nxt;
  logic                      match;
  logic                      wr_hit;

  assign match  = tok_in.vld && valid_r && (key_r == tok_in.key);
  assign wr_hit = wr.en && (wr.idx == my_idx);

  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit = 1'b1;
      if (tok_in.cmd == kvt_pkg::CMD_LOOKUP) begin
        tok_nxt.fval = value_r;
      end
    end
    // first free entry along the chain is the insert target
    if (tok_in.vld && !valid_r && !tok_in.free_seen) begin
      tok_nxt.free_seen = 1'b1;
      tok_nxt.free_idx  = my_idx;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (match && (tok_in.cmd == kvt_pkg::CMD_ERASE)) begin
      valid_nxt = 1'b0;
    end
    if (wr_hit) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      key_r   <= wr.key;
      value_r <= wr.value;
    end
  end

  assign tok_out = tok_r;

endmodule

/* hdl/key_value_table.sv */
// ----------------------------------------------------------------------------
// key_value_table
// Associative table of unique 32-bit keys with 32-bit values: insert, lookup
// and erase, one result item per request.
// ----------------------------------------------------------------------------
// One request is handled at a time: in_ready is high only in the idle state.
// The search item walks the row of TABLE_DEPTH entry cells one cell per cycle,
// collecting the hit, the looked-up value and the first free entry. The
// finished item is then latched. The done state writes an inserted entry,
// updates the count and loads the result, and the block returns to idle, where
// in_ready is high again. A request that has finished its walk waits until
// the previous result item has been taken, so a slow out_ready stalls the
// block. The table is empty after reset, with no clearing pass.
module key_value_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_found_value,
  output logic [6:0]         out_entry_count,
  output logic               out_is_empty
);

  localparam int D = kvt_pkg::TABLE_DEPTH;

  kvt_pkg::state_t           state_r;
  kvt_pkg::state_t           state_nxt;
  kvt_pkg::tok_t             tok0_r;
  kvt_pkg::tok_t             fin_r;
  kvt_pkg::tok_t             chain [D];
  kvt_pkg::wr_t              wr;
  logic [kvt_pkg::VAL_W-1:0] ins_val_r;
  logic [kvt_pkg::CNT_W-1:0] count_r;
  logic [kvt_pkg::CNT_W-1:0] count_nxt;
  logic                      finish;
  logic                      accept;
  kvt_pkg::status_t          status;
  logic [kvt_pkg::CNT_W+kvt_pkg::OUT_CNT_W-1:0] cnt_ext;

  logic                      out_valid_r;
  logic [1:0]                out_status_r;
  logic [31:0]               out_found_value_r;
  logic [6:0]                out_entry_count_r;
  logic                      out_is_empty_r;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == kvt_pkg::S_IDLE);

  // cell row
  for (genvar i = 0; i < D; i++) begin : g_cell
    if (i == 0) begin : g_first
      kvt_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .my_idx  (kvt_pkg::IDX_W'(i)),
        .tok_in  (tok0_r),
        .wr      (wr),
        .tok_out (chain[i])
      );
    end else begin : g_rest
      kvt_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .my_idx  (kvt_pkg::IDX_W'(i)),
        .tok_in  (chain[i-1]),
        .wr      (wr),
        .tok_out (chain[i])
      );
    end
  end

  // launch of a new search item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r.vld <= 1'b0;
    end else begin
      tok0_r.vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok0_r.cmd       <= kvt_pkg::cmd_t'(in_cmd);
      tok0_r.key       <= $unsigned(in_key);
      tok0_r.hit       <= 1'b0;
      tok0_r.free_seen <= 1'b0;
      tok0_r.free_idx  <= '0;
      tok0_r.fval      <= '0;
      ins_val_r        <= $unsigned(in_value);
    end
    if (chain[D-1].vld) begin
      fin_r <= chain[D-1];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kvt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    finish    = 1'b0;
    case (state_r)
      kvt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = kvt_pkg::S_BUSY;
      end
      kvt_pkg::S_BUSY: begin
        if (chain[D-1].vld) state_nxt = kvt_pkg::S_DONE;
      end
      kvt_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          finish    = 1'b1;
          state_nxt = kvt_pkg::S_IDLE;
        end
      end
      default: state_nxt = kvt_pkg::S_IDLE;
    endcase
  end

  // result of the finished search
  always_comb begin
    status    = kvt_pkg::ST_OK;
    count_nxt = count_r;
    wr.en     = 1'b0;
    wr.idx    = fin_r.free_idx;
    wr.key    = fin_r.key;
    wr.value  = ins_val_r;
    case (fin_r.cmd)
      kvt_pkg::CMD_INSERT: begin
        if (fin_r.hit) begin
          status = kvt_pkg::ST_DUPLICATE;
        end else if (!fin_r.free_seen) begin
          status = kvt_pkg::ST_FULL;
        end else begin
          wr.en     = finish;
          count_nxt = count_r + kvt_pkg::CNT_W'(1);
        end
      end
      kvt_pkg::CMD_LOOKUP: begin
        if (!fin_r.hit) status = kvt_pkg::ST_NOT_FOUND;
      end
      kvt_pkg::CMD_ERASE: begin
        if (!fin_r.hit) begin
          status = kvt_pkg::ST_NOT_FOUND;
        end else begin
          count_nxt = count_r - kvt_pkg::CNT_W'(1);
        end
      end
      default: status = kvt_pkg::ST_OK;
    endcase
  end

  assign cnt_ext = {{kvt_pkg::OUT_CNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status_r      <= status;
      out_found_value_r <= fin_r.fval;
      out_entry_count_r <= cnt_ext[kvt_pkg::OUT_CNT_W-1:0];
      out_is_empty_r    <= (count_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = $signed(out_found_value_r);
  assign out_entry_count = out_entry_count_r;
  assign out_is_empty    = out_is_empty_r;

endmodule

/* tb/tb_key_value_table.sv */
// ----------------------------------------------------------------------------
// tb_key_value_table
// Self-checking bench for the key/value table. Requests go in through a
// queue-fed driver, and each result is checked against a table model kept
// in the bench. Includes directed corner cases, then random fill/drain/mix
// phases over a small key pool, with random gaps on both sides and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_key_value_table;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM    = 530;
  localparam int POOL_N      = 96;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SQUEEZE_AT  = 150;
  localparam int SQUEEZE_LEN = 600;
  localparam int DRAIN_WAIT  = 100;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct {
    kvt_pkg::cmd_t      cmd;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } kv_req_t;

  typedef struct {
    kvt_pkg::status_t   status;
    logic signed [31:0] found_value;
    logic [6:0]         entry_count;
    logic               is_empty;
  } kv_result_t;

  typedef enum int {GEN_FILL, GEN_DRAIN, GEN_MIX} gen_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd = kvt_pkg::CMD_NOP;
  logic signed [31:0] in_key = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_found_value;
  logic [6:0]         out_entry_count;
  logic               out_is_empty;

  key_value_table i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  always #5 clk = ~clk;

  // Table contents as the bench sees them
  logic signed [31:0] tbl_key [kvt_pkg::TABLE_DEPTH];
  logic signed [31:0] tbl_val [kvt_pkg::TABLE_DEPTH];
  bit                 tbl_used [kvt_pkg::TABLE_DEPTH];
  int                 tbl_count = 0;

  kv_req_t    pending_q [$];
  kv_result_t expect_q [$];

  int  errors = 0;
  int  accepted = 0;
  int  results_seen = 0;
  int  peak_count = 0;
  int  status_seen [4];
  bit  in_acc = 1'b0;

  // Steering state for the generator only
  logic signed [31:0] pool_key [POOL_N];
  bit                 pool_live [POOL_N];
  int                 pool_live_n = 0;

  function automatic kv_result_t table_apply(kv_req_t rq);
    kv_result_t res;
    int hit = -1;
    int spare = -1;
    res.status      = kvt_pkg::ST_OK;
    res.found_value = '0;
    for (int i = 0; i < kvt_pkg::TABLE_DEPTH; i++) begin
      if (tbl_used[i] && tbl_key[i] == rq.key && hit < 0) hit = i;
      if (!tbl_used[i] && spare < 0) spare = i;
    end
    case (rq.cmd)
      kvt_pkg::CMD_INSERT: begin
        if (hit >= 0) begin
          res.status = kvt_pkg::ST_DUPLICATE;
        end else if (spare < 0) begin
          res.status = kvt_pkg::ST_FULL;
        end else begin
          tbl_key[spare]  = rq.key;
          tbl_val[spare]  = rq.value;
          tbl_used[spare] = 1'b1;
          tbl_count++;
        end
      end
      kvt_pkg::CMD_LOOKUP: begin
        if (hit >= 0) res.found_value = tbl_val[hit];
        else res.status = kvt_pkg::ST_NOT_FOUND;
      end
      kvt_pkg::CMD_ERASE: begin
        if (hit >= 0) begin
          tbl_used[hit] = 1'b0;
          tbl_count--;
        end else begin
          res.status = kvt_pkg::ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    res.entry_count = 7'(tbl_count);
    res.is_empty    = (tbl_count == 0);
    return res;
  endfunction

  task automatic queue_req(kvt_pkg::cmd_t c, logic signed [31:0] k, logic signed [31:0] v);
    kv_req_t rq;
    rq.cmd   = c;
    rq.key   = k;
    rq.value = v;
    pending_q.push_back(rq);
  endtask

  // Mostly back-to-back, now and then a long pause
  function automatic int idle_len(bit quiet);
    int r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic int pick_pool(bit want_live);
    int idx;
    for (int t = 0; t < 200; t++) begin
      idx = $urandom_range(0, POOL_N - 1);
      if (pool_live[idx] == want_live) return idx;
    end
    return $urandom_range(0, POOL_N - 1);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    errors++;
  endtask

  // Stimulus
  initial begin
    gen_mode_t     mode;
    int            left;
    int            made;
    int            r;
    int            idx;
    kvt_pkg::cmd_t c;
    bit            first;

    foreach (tbl_used[i]) tbl_used[i] = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Directed: empty table, extreme keys, duplicate, unused code, drain back
    queue_req(kvt_pkg::CMD_LOOKUP, 32'sd0, 32'sd0);
    queue_req(kvt_pkg::CMD_ERASE,  KEY_MIN, 32'sd0);
    queue_req(kvt_pkg::CMD_INSERT, KEY_MIN, KEY_MAX);
    queue_req(kvt_pkg::CMD_INSERT, KEY_MAX, KEY_MIN);
    queue_req(kvt_pkg::CMD_INSERT, 32'sd0, 32'sd0);
    queue_req(kvt_pkg::CMD_INSERT, -32'sd1, -32'sd1);
    queue_req(kvt_pkg::CMD_INSERT, KEY_MAX, 32'sd123);
    queue_req(kvt_pkg::CMD_LOOKUP, KEY_MIN, 32'sd0);
    queue_req(kvt_pkg::CMD_LOOKUP, KEY_MAX, 32'sd0);
    queue_req(kvt_pkg::CMD_LOOKUP, -32'sd1, 32'sd0);
    queue_req(kvt_pkg::CMD_LOOKUP, 32'sd1, 32'sd0);
    queue_req(kvt_pkg::CMD_NOP,    KEY_MAX, -32'sd1);
    queue_req(kvt_pkg::CMD_ERASE,  KEY_MIN, 32'sd0);
    queue_req(kvt_pkg::CMD_LOOKUP, KEY_MIN, 32'sd0);
    queue_req(kvt_pkg::CMD_ERASE,  KEY_MIN, 32'sd0);
    queue_req(kvt_pkg::CMD_INSERT, 32'sh5a5a_5a5a, 32'sha5a5_a5a5);
    queue_req(kvt_pkg::CMD_LOOKUP, 32'sh5a5a_5a5a, 32'sd0);
    queue_req(kvt_pkg::CMD_ERASE,  KEY_MAX, 32'sd0);
    queue_req(kvt_pkg::CMD_ERASE,  32'sd0, 32'sd0);
    queue_req(kvt_pkg::CMD_ERASE,  -32'sd1, 32'sd0);
    queue_req(kvt_pkg::CMD_ERASE,  32'sh5a5a_5a5a, 32'sd0);
    queue_req(kvt_pkg::CMD_NOP,    32'sd0, 32'sd0);

    // Random: phases over a key pool larger than the table, so it fills up
    pool_key[0] = KEY_MIN;
    pool_key[1] = KEY_MAX;
    pool_key[2] = 32'sd0;
    pool_key[3] = -32'sd1;
    for (int i = 4; i < POOL_N; i++) pool_key[i] = $urandom;
    foreach (pool_live[i]) pool_live[i] = 1'b0;

    left  = 0;
    made  = 0;
    first = 1'b1;
    mode  = GEN_FILL;
    while (made < N_RANDOM) begin
      if (left == 0) begin
        mode  = first ? GEN_FILL : gen_mode_t'($urandom_range(0, 2));
        left  = first ? 100 : $urandom_range(40, 110);
        first = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // noise: any code, any key
        c = kvt_pkg::cmd_t'($urandom_range(0, 3));
        queue_req(c, $urandom, $urandom);
      end else begin
        r = $urandom_range(0, 99);
        case (mode)
          GEN_FILL:  c = (r < 75) ? kvt_pkg::CMD_INSERT :
                         (r < 90) ? kvt_pkg::CMD_LOOKUP : kvt_pkg::CMD_ERASE;
          GEN_DRAIN: c = (r < 10) ? kvt_pkg::CMD_INSERT :
                         (r < 30) ? kvt_pkg::CMD_LOOKUP : kvt_pkg::CMD_ERASE;
          default:   c = (r < 35) ? kvt_pkg::CMD_INSERT :
                         (r < 70) ? kvt_pkg::CMD_LOOKUP : kvt_pkg::CMD_ERASE;
        endcase
        r = $urandom_range(0, 99);
        if (c == kvt_pkg::CMD_INSERT) idx = pick_pool(r >= 80);
        else idx = pick_pool(r < 80);
        if (c == kvt_pkg::CMD_INSERT && !pool_live[idx] &&
            pool_live_n < kvt_pkg::TABLE_DEPTH) begin
          pool_live[idx] = 1'b1;
          pool_live_n++;
        end else if (c == kvt_pkg::CMD_ERASE && pool_live[idx]) begin
          pool_live[idx] = 1'b0;
          pool_live_n--;
        end
        queue_req(c, pool_key[idx], $urandom);
      end
      if (c != kvt_pkg::CMD_NOP) made++;
      left--;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d requests; status ok %0d, not found %0d, duplicate %0d, full %0d",
             accepted, status_seen[kvt_pkg::ST_OK], status_seen[kvt_pkg::ST_NOT_FOUND],
             status_seen[kvt_pkg::ST_DUPLICATE], status_seen[kvt_pkg::ST_FULL]);
    $display("table peaked at %0d of %0d entries; one output hold-off of %0d cycles",
             peak_count, kvt_pkg::TABLE_DEPTH, SQUEEZE_LEN);
    if (errors == 0) begin
      $display("tb_key_value_table: done, clean");
    end else begin
      $display("tb_key_value_table: done, errors");
    end
    $finish;
  end

  // Accepted requests go through the table model
  always @(posedge clk) begin
    kv_req_t rq;
    in_acc <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      rq.cmd   = kvt_pkg::cmd_t'(in_cmd);
      rq.key   = in_key;
      rq.value = in_value;
      expect_q.push_back(table_apply(rq));
      accepted++;
      if (tbl_count > peak_count) peak_count = tbl_count;
    end
  end

  // Driver
  int tx_gap = 0;
  bit tx_quiet = 1'b0;

  always @(negedge clk) begin
    kv_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        in_valid <= 1'b1;
        in_cmd   <= nxt.cmd;
        in_key   <= nxt.key;
        in_value <= nxt.value;
        if ($urandom_range(0, 99) < 3) tx_quiet = !tx_quiet;
        tx_gap = idle_len(tx_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off so the block backs up onto its input
  int rx_hold = 0;
  bit rx_quiet = 1'b0;
  bit squeeze_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
        rx_hold      = SQUEEZE_LEN;
        squeeze_done = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 3) rx_quiet = !rx_quiet;
        rx_hold = idle_len(rx_quiet);
        out_ready <= (rx_hold == 0);
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    kv_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expect_q.size() == 0) begin
        report_mismatch("unexpected result item, status", '0, 32'(out_status));
      end else begin
        want = expect_q.pop_front();
        status_seen[want.status]++;
        if (out_status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_status));
        if (out_found_value !== want.found_value)
          report_mismatch("found_value", want.found_value, out_found_value);
        if (out_entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(want.entry_count), 32'(out_entry_count));
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(want.is_empty), 32'(out_is_empty));
      end
    end
  end

  // Watchdog: cycles with no item moving on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t ns: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_key_value_table: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
